// ===== src/aabb_pair_sweep_defines.svh =====
// ----------------------------------------------------------------------------
// AABB pair sweep assertion macros
// Shared property shorthands for the sweep block checks.
// ----------------------------------------------------------------------------
`ifndef AABB_PAIR_SWEEP_DEFINES_SVH
`define AABB_PAIR_SWEEP_DEFINES_SVH

// Check that an expression holds at every clock edge out of reset.
`define APS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define APS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// AABB pair sweep package
// Sizes, entry types and the coordinate helper for the box table.
// ----------------------------------------------------------------------------
package aps_pkg;

    // Table depth and coordinate width
    localparam int unsigned NUM_BOXES  = 8;
    localparam int unsigned COORD_BITS = 16;

    // Table index width
    localparam int unsigned IDX_BITS = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;

    // Signed width of the overlap arithmetic: holds 2*(ca-cb) and sa+sb
    localparam int unsigned CALC_BITS = ((COORD_BITS > 15) ? COORD_BITS : 15) + 4;

    // Layer codes
    localparam logic [1:0] LAYER_NONE = 2'd0;

    // Geometry of one box entry
    typedef struct packed {
        logic [15:0] cy;
        logic [15:0] cx;
        logic [14:0] h;
        logic [14:0] w;
    } t_geo;

    // Flags of one box entry
    typedef struct packed {
        logic [1:0] tgt;
        logic [1:0] own;
        logic       enabled;
    } t_flags;

    // Wrap a 16-bit signed field to COORD_BITS and widen to CALC_BITS
    function automatic logic signed [CALC_BITS-1:0] to_coord(input logic [15:0] v);
        logic signed [COORD_BITS-1:0] c;
        c = COORD_BITS'(signed'(v));
        return CALC_BITS'(c);
    endfunction

endpackage

// ===== src/aabb_pair_sweep.sv =====
// ----------------------------------------------------------------------------
// AABB pair sweep
// Box table with an all-pairs overlap sweep filtered by layer masks.
// ----------------------------------------------------------------------------
// A request with i_mode low writes one box entry; busy stays low. A request
// with i_mode high runs a sweep: each enabled source with a target layer is
// loaded from the table, then every entry, the source itself included, is
// scanned one per cycle, except that an entry other than the source on the
// target layer holds the scan for the x axis test and, if x overlaps, for the
// y axis test. The summary is strobed in the cycle in which busy drops. The
// pace of the sweep is set by the single read port of the geometry table and
// the one axis comparator that is reused for every test. Each hit and the
// closing summary appear for one cycle on o_strobe; there is no backpressure,
// so the receiver must take every result as it comes.
module aabb_pair_sweep (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [2:0]  i_box_index,
    input  logic [15:0] i_centre_x,
    input  logic [15:0] i_centre_y,
    input  logic [14:0] i_box_width,
    input  logic [14:0] i_box_height,
    input  logic        i_box_enabled,
    input  logic [1:0]  i_own_layer,
    input  logic [1:0]  i_target_layer,
    output logic        o_strobe,
    output logic        o_hit_valid,
    output logic [2:0]  o_source_index,
    output logic [2:0]  o_target_index,
    output logic [5:0]  o_hit_total,
    output logic        o_last
);

    `include "aabb_pair_sweep_defines.svh"

    localparam int unsigned IW = aps_pkg::IDX_BITS;
    localparam int unsigned CW = aps_pkg::CALC_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(aps_pkg::NUM_BOXES - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRC  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_AX   = 3'd4;
    localparam logic [2:0] S_AY   = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;

    // Table storage
    aps_pkg::t_geo   m_geo [aps_pkg::NUM_BOXES];
    aps_pkg::t_flags r_flags [aps_pkg::NUM_BOXES];
    aps_pkg::t_geo   r_rd;
    aps_pkg::t_geo   r_src;

    // Sequencer registers
    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [1:0]    r_tgt, n_tgt;
    logic [5:0]    r_hit_cnt, n_hit_cnt;

    // Result registers
    logic       r_strobe, n_strobe;
    logic       r_hit_valid, n_hit_valid;
    logic [2:0] r_source_index, n_source_index;
    logic [2:0] r_target_index, n_target_index;
    logic [5:0] r_hit_total, n_hit_total;
    logic       r_last, n_last;

    // Request decode and table access
    logic          wr_en;
    logic          sweep_req;
    logic          src_ok;
    logic          dst_ok;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    // Shared axis unit
    logic [15:0]          ax_ca_raw, ax_cb_raw;
    logic [14:0]          ax_sa, ax_sb;
    logic signed [CW-1:0] ax_diff2;
    logic signed [CW-1:0] ax_sum;
    logic                 ax_hit;

    assign busy      = (r_state != S_IDLE);
    assign sweep_req = start && !busy && i_mode;
    assign wr_en     = start && !busy && !i_mode &&
                       (4'(i_box_index) < 4'(aps_pkg::NUM_BOXES));

    assign src_ok  = r_flags[r_i].enabled && (r_flags[r_i].tgt != aps_pkg::LAYER_NONE);
    assign dst_ok  = (r_j != r_i) && (r_flags[r_j].own == r_tgt);
    assign rd_en   = ((r_state == S_SRC) && src_ok) || ((r_state == S_SCAN) && dst_ok);
    assign rd_addr = (r_state == S_SRC) ? r_i : r_j;

    // Store geometry and read one entry per cycle while a read is enabled
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_geo[i_box_index[IW-1:0]] <= '{cy: i_centre_y, cx: i_centre_x,
                                           h: i_box_height, w: i_box_width};
        end
        if (rd_en) begin
            r_rd <= m_geo[rd_addr];
        end
        if (r_state == S_LOAD) begin
            r_src <= r_rd;
        end
    end

    // Store flags, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < aps_pkg::NUM_BOXES; k++) begin
                r_flags[k] <= '0;
            end
        end else if (wr_en) begin
            r_flags[i_box_index[IW-1:0]] <= '{tgt: i_target_layer, own: i_own_layer,
                                              enabled: i_box_enabled};
        end
    end

    // Test one axis: overlap when |2*(ca-cb)| <= sa+sb
    always_comb begin
        if (r_state == S_AY) begin
            ax_ca_raw = r_src.cy;
            ax_cb_raw = r_rd.cy;
            ax_sa     = r_src.h;
            ax_sb     = r_rd.h;
        end else begin
            ax_ca_raw = r_src.cx;
            ax_cb_raw = r_rd.cx;
            ax_sa     = r_src.w;
            ax_sb     = r_rd.w;
        end
        ax_diff2 = (aps_pkg::to_coord(ax_ca_raw) - aps_pkg::to_coord(ax_cb_raw)) <<< 1;
        ax_sum   = signed'(CW'(ax_sa)) + signed'(CW'(ax_sb));
        ax_hit   = (ax_diff2 <= ax_sum) && (ax_diff2 >= -ax_sum);
    end

    // Sequence the sweep
    always_comb begin
        logic adv_j;
        adv_j          = 1'b0;
        n_state        = r_state;
        n_i            = r_i;
        n_j            = r_j;
        n_tgt          = r_tgt;
        n_hit_cnt      = r_hit_cnt;
        n_strobe       = 1'b0;
        n_hit_valid    = r_hit_valid;
        n_source_index = r_source_index;
        n_target_index = r_target_index;
        n_hit_total    = r_hit_total;
        n_last         = r_last;

        case (r_state)
            S_IDLE: begin
                if (sweep_req) begin
                    n_i       = '0;
                    n_hit_cnt = '0;
                    n_state   = S_SRC;
                end
            end
            S_SRC: begin
                if (src_ok) begin
                    n_tgt   = r_flags[r_i].tgt;
                    n_j     = '0;
                    n_state = S_LOAD;
                end else if (r_i == LAST_IDX) begin
                    n_state = S_SUM;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_LOAD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (dst_ok) begin
                    n_state = S_AX;
                end else begin
                    adv_j = 1'b1;
                end
            end
            S_AX: begin
                if (ax_hit) begin
                    n_state = S_AY;
                end else begin
                    adv_j = 1'b1;
                end
            end
            S_AY: begin
                if (ax_hit) begin
                    n_strobe       = 1'b1;
                    n_hit_valid    = 1'b1;
                    n_source_index = 3'(r_i);
                    n_target_index = 3'(r_j);
                    n_hit_total    = '0;
                    n_last         = 1'b0;
                    n_hit_cnt      = r_hit_cnt + 1'b1;
                end
                adv_j = 1'b1;
            end
            S_SUM: begin
                n_strobe       = 1'b1;
                n_hit_valid    = 1'b0;
                n_source_index = '0;
                n_target_index = '0;
                n_hit_total    = r_hit_cnt;
                n_last         = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the next partner, then to the next source
        if (adv_j) begin
            if (r_j != LAST_IDX) begin
                n_j     = r_j + 1'b1;
                n_state = S_SCAN;
            end else if (r_i != LAST_IDX) begin
                n_i     = r_i + 1'b1;
                n_state = S_SRC;
            end else begin
                n_state = S_SUM;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_hit_cnt <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_tgt     <= aps_pkg::LAYER_NONE;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_hit_cnt <= n_hit_cnt;
            r_i       <= n_i;
            r_j       <= n_j;
            r_tgt     <= n_tgt;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        r_hit_valid    <= n_hit_valid;
        r_source_index <= n_source_index;
        r_target_index <= n_target_index;
        r_hit_total    <= n_hit_total;
        r_last         <= n_last;
    end

    assign o_strobe       = r_strobe;
    assign o_hit_valid    = r_hit_valid;
    assign o_source_index = r_source_index;
    assign o_target_index = r_target_index;
    assign o_hit_total    = r_hit_total;
    assign o_last         = r_last;

    // Checks
    `APS_ASSERT_IMPLY(a_kind_unique, o_strobe, o_hit_valid != o_last, "hit and summary mixed")
    `APS_ASSERT_IMPLY(a_no_self_hit, o_strobe && o_hit_valid, o_source_index != o_target_index,
        "entry reported against itself")
    `APS_ASSERT_IMPLY(a_summary_ends, o_strobe && o_last, !busy, "summary before sweep end")
    `APS_ASSERT_IMPLY(a_count_clear, $rose(busy), r_hit_cnt == '0, "hit count not cleared")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// AABB pair sweep testbench
// Drives box-table writes and sweeps through the start/busy handshake and
// checks every strobed result against an in-bench prediction of the table.
// A directed table covers touching and near-miss boxes, the coordinate and
// size extremes, layer filtering, disabled sources and a full 56-hit sweep.
// Clustered random traffic with random sender gaps follows.
// ----------------------------------------------------------------------------
module tb;

    localparam logic       MODE_WRITE   = 1'b0;
    localparam logic       MODE_SWEEP   = 1'b1;
    localparam logic [1:0] LAYER_PLAYER = 2'd1;
    localparam logic [1:0] LAYER_ENEMY  = 2'd2;
    localparam logic [1:0] LAYER_SPARE  = 2'd3;

    localparam int RANDOM_REQUESTS = 400;
    localparam int MAX_GAP         = 12;
    localparam int DRAIN_CYCLES    = 200;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef struct packed {
        logic        mode;
        logic [2:0]  idx;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [14:0] w;
        logic [14:0] h;
        logic        en;
        logic [1:0]  own;
        logic [1:0]  tgt;
    } t_box_req;

    typedef struct packed {
        logic       hit;
        logic [2:0] src;
        logic [2:0] dst;
        logic [5:0] total;
        logic       last;
    } t_sweep_result;

    typedef struct {
        t_box_req   req;
        bit         typed;
        logic [5:0] total;
    } t_dir_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        i_mode         = 1'b0;
    logic [2:0]  i_box_index    = '0;
    logic [15:0] i_centre_x     = '0;
    logic [15:0] i_centre_y     = '0;
    logic [14:0] i_box_width    = '0;
    logic [14:0] i_box_height   = '0;
    logic        i_box_enabled  = 1'b0;
    logic [1:0]  i_own_layer    = '0;
    logic [1:0]  i_target_layer = '0;
    logic        busy;
    logic        o_strobe;
    logic        o_hit_valid;
    logic [2:0]  o_source_index;
    logic [2:0]  o_target_index;
    logic [5:0]  o_hit_total;
    logic        o_last;

    // Predicted table contents and pending sweep results
    aps_pkg::t_geo   geo_tab  [aps_pkg::NUM_BOXES];
    aps_pkg::t_flags flag_tab [aps_pkg::NUM_BOXES] = '{default: '0};
    t_sweep_result   pending_results[$];
    int              mismatches  = 0;
    int unsigned     cycle_count = 0;

    aabb_pair_sweep DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_box_index    (i_box_index),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_box_enabled  (i_box_enabled),
        .i_own_layer    (i_own_layer),
        .i_target_layer (i_target_layer),
        .o_strobe       (o_strobe),
        .o_hit_valid    (o_hit_valid),
        .o_source_index (o_source_index),
        .o_target_index (o_target_index),
        .o_hit_total    (o_hit_total),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Append one expected result at the tail of the queue
    function automatic void queue_result(input t_sweep_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Sign-extend a 16-bit centre, then wrap it to the coordinate width
    function automatic longint wrap_coord(input logic [15:0] v);
        longint c;
        c = longint'(signed'(v));
        c = (c <<< (64 - aps_pkg::COORD_BITS)) >>> (64 - aps_pkg::COORD_BITS);
        return c;
    endfunction

    // Union extent against summed size on one axis, doubled units, touch hits
    function automatic bit axis_overlap(input logic [15:0] ca, input logic [14:0] sa,
                                        input logic [15:0] cb, input logic [14:0] sb);
        longint pa, pb, wa, wb, hi, lo;
        pa = 2 * wrap_coord(ca);
        pb = 2 * wrap_coord(cb);
        wa = sa;
        wb = sb;
        hi = (pa + wa > pb + wb) ? pa + wa : pb + wb;
        lo = (pa - wa < pb - wb) ? pa - wa : pb - wb;
        return (hi - lo <= 2 * (wa + wb));
    endfunction

    // Store one entry, or queue the hits and summary of a sweep
    task automatic apply_box_request(input t_box_req r);
        int hits;
        if (r.mode == MODE_WRITE) begin
            if (r.idx < aps_pkg::NUM_BOXES) begin
                geo_tab[r.idx]  = aps_pkg::t_geo'{cy: r.cy, cx: r.cx, h: r.h, w: r.w};
                flag_tab[r.idx] = aps_pkg::t_flags'{tgt: r.tgt, own: r.own, enabled: r.en};
            end
        end else begin
            hits = 0;
            for (int s = 0; s < aps_pkg::NUM_BOXES; s++) begin
                if (!flag_tab[s].enabled || flag_tab[s].tgt == aps_pkg::LAYER_NONE) continue;
                for (int d = 0; d < aps_pkg::NUM_BOXES; d++) begin
                    if (d == s || flag_tab[d].own != flag_tab[s].tgt) continue;
                    if (axis_overlap(geo_tab[s].cx, geo_tab[s].w, geo_tab[d].cx, geo_tab[d].w)
                        && axis_overlap(geo_tab[s].cy, geo_tab[s].h,
                                        geo_tab[d].cy, geo_tab[d].h)) begin
                        queue_result(t_sweep_result'{hit: 1'b1, src: 3'(s),
                            dst: 3'(d), total: 6'd0, last: 1'b0});
                        hits++;
                    end
                end
            end
            queue_result(t_sweep_result'{hit: 1'b0, src: 3'd0, dst: 3'd0,
                total: 6'(hits), last: 1'b1});
        end
    endtask

    // Present one request after an idle gap and hold it until accepted
    task automatic issue_request(input t_box_req r, input int gap, input bit typed,
                                 input logic [5:0] typed_total);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode         <= r.mode;
        i_box_index    <= r.idx;
        i_centre_x     <= r.cx;
        i_centre_y     <= r.cy;
        i_box_width    <= r.w;
        i_box_height   <= r.h;
        i_box_enabled  <= r.en;
        i_own_layer    <= r.own;
        i_target_layer <= r.tgt;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (typed) begin
            queue_result(t_sweep_result'{hit: 1'b0, src: 3'd0, dst: 3'd0,
                total: typed_total, last: 1'b1});
        end else begin
            apply_box_request(r);
        end
        @(negedge i_clk);
    endtask

    // Stop sending until every queued result has come out
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic t_dir_row write_row(input logic [2:0] idx, input int cx, input int cy,
                                           input int w, input int h, input logic en,
                                           input logic [1:0] own, input logic [1:0] tgt);
        t_dir_row row;
        row.req   = t_box_req'{mode: MODE_WRITE, idx: idx, cx: 16'(cx), cy: 16'(cy),
                               w: 15'(w), h: 15'(h), en: en, own: own, tgt: tgt};
        row.typed = 1'b0;
        row.total = '0;
        return row;
    endfunction

    function automatic t_dir_row sweep_row(input bit typed, input logic [5:0] total);
        t_dir_row row;
        row.req      = '0;
        row.req.mode = MODE_SWEEP;
        row.typed    = typed;
        row.total    = total;
        return row;
    endfunction

    // Mostly writes clustered near the origin so pairs overlap, some wide noise
    function automatic t_box_req random_box_request();
        t_box_req r;
        int       pick;
        pick  = $urandom_range(0, 99);
        r.idx = 3'($urandom);
        r.cx  = 16'($urandom);
        r.cy  = 16'($urandom);
        r.w   = 15'($urandom);
        r.h   = 15'($urandom);
        r.en  = 1'($urandom);
        r.own = 2'($urandom);
        r.tgt = 2'($urandom);
        r.mode = (pick < 22) ? MODE_SWEEP : MODE_WRITE;
        if (r.mode == MODE_WRITE && pick >= 40) begin
            r.cx = 16'($urandom_range(0, 511) - 256);
            r.cy = 16'($urandom_range(0, 511) - 256);
            r.w  = 15'($urandom_range(0, 400));
            r.h  = 15'($urandom_range(0, 400));
            r.en = ($urandom_range(0, 3) != 0);
        end
        return r;
    endfunction

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_sweep_result seen, want;
        if (i_rst_n && o_strobe === 1'b1) begin
            seen = t_sweep_result'{hit: o_hit_valid, src: o_source_index,
                dst: o_target_index, total: o_hit_total, last: o_last};
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got hit=%0d src=%0d dst=%0d "
                         , $time, seen.hit, seen.src, seen.dst,
                         "total=%0d last=%0d", seen.total, seen.last);
            end else begin
                want = pending_results.pop_front();
                if (seen.hit !== want.hit || seen.src !== want.src || seen.dst !== want.dst
                    || seen.total !== want.total || seen.last !== want.last) begin
                    mismatches++;
                    $display("%0t: result mismatch, expected hit=%0d src=%0d dst=%0d ",
                             $time, want.hit, want.src, want.dst,
                             "total=%0d last=%0d, got hit=%0d src=%0d dst=%0d ",
                             want.total, want.last, seen.hit, seen.src, seen.dst,
                             "total=%0d last=%0d", seen.total, seen.last);
                end
            end
        end
    end

    initial begin
        t_dir_row rows [24];
        int       gap;
        rows = '{
            // empty table right after reset: summary only
            sweep_row(1'b1, 6'd0),
            // touching on x, then a one-unit gap
            write_row(3'd0, 0, 0, 32, 32, 1'b1, LAYER_PLAYER, LAYER_ENEMY),
            write_row(3'd1, 32, 0, 32, 32, 1'b0, LAYER_ENEMY, aps_pkg::LAYER_NONE),
            sweep_row(1'b0, 6'd0),
            write_row(3'd2, 33, 0, 32, 32, 1'b0, LAYER_ENEMY, aps_pkg::LAYER_NONE),
            // coordinate and size extremes, zero-size point boxes, self skip
            write_row(3'd3, -32768, 32767, 32767, 32767, 1'b1, LAYER_ENEMY, LAYER_PLAYER),
            write_row(3'd4, 32767, -32768, 0, 0, 1'b1, LAYER_SPARE, LAYER_SPARE),
            write_row(3'd5, 32767, -32768, 0, 0, 1'b0, LAYER_SPARE, aps_pkg::LAYER_NONE),
            sweep_row(1'b0, 6'd0),
            write_row(3'd6, -1, -1, 32767, 32767, 1'b1, LAYER_SPARE, LAYER_ENEMY),
            write_row(3'd7, 0, 0, 32767, 32767, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            sweep_row(1'b0, 6'd0),
            // disabled source, enabled source with no target layer
            write_row(3'd0, 0, 0, 32, 32, 1'b0, LAYER_PLAYER, LAYER_ENEMY),
            write_row(3'd1, 32, 0, 32, 32, 1'b1, LAYER_ENEMY, aps_pkg::LAYER_NONE),
            sweep_row(1'b0, 6'd0),
            // every entry strikes every other: full hit count
            write_row(3'd0, 0, 0, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd1, 10, -10, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd2, -20, 5, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd3, 30, 30, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd4, -30, -30, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd5, 0, 40, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd6, 40, 0, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            write_row(3'd7, -5, -5, 100, 100, 1'b1, LAYER_PLAYER, LAYER_PLAYER),
            sweep_row(1'b0, 6'd0)
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (rows[k]) begin
            gap = (k % 3 == 0) ? $urandom_range(0, MAX_GAP) : 0;
            issue_request(rows[k].req, gap, rows[k].typed, rows[k].total);
        end
        hold_until_drained();

        // Random traffic, with back-to-back stretches
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            gap = ((n / 30) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            issue_request(random_box_request(), gap, 1'b0, 6'd0);
            if (n == RANDOM_REQUESTS / 2) hold_until_drained();
        end
        start <= 1'b0;

        // Drain, then watch for stray results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
